/* rtl/bsca_pkg.sv */
// ============================================================================
// bsca_pkg
// Shared widths, constants, codes and the sequencer program for the
// barometric compensation block.
// ============================================================================
`default_nettype none

package bsca_pkg;

    localparam int DEF_WINDOW = 10;

    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int VAL_W     = 32;
    localparam int AVG_W     = 36;

    localparam int DT_W   = 26;
    localparam int TEMP_W = 20;
    localparam int OS_W   = 40;
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 62;

    localparam int REF_TEMP_SHIFT = 8;
    localparam int TEMP_SHIFT     = 23;
    localparam int OFFSET_SHIFT   = 16;
    localparam int OFF_TC_SHIFT   = 7;
    localparam int SENS_SHIFT     = 15;
    localparam int SENS_TC_SHIFT  = 8;
    localparam int DT2_SHIFT      = 31;
    localparam int P_SHIFT        = 21;
    localparam int P_DIV_SHIFT    = 15;
    localparam int SENS_SPLIT     = 20;
    localparam int Q_FRAC         = 4;
    localparam int DIGITS         = 8;

    localparam logic signed [TEMP_W-1:0] TEMP_REF = TEMP_W'(2000);

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DT,
        OP_TEMP,
        OP_OFF,
        OP_SENS,
        OP_LOWCORR,
        OP_TEMP2,
        OP_ACC_LO,
        OP_ACC_HI,
        OP_PDIFF,
        OP_PRES,
        OP_SUMS,
        OP_DIV,
        OP_EMIT
    } alu_op_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DT_SLOPE,
        MUL_DT_OFF_TC,
        MUL_DT_SENS_TC,
        MUL_TD_SQ,
        MUL_DT_SQ,
        MUL_RAW_SLO,
        MUL_RAW_SHI
    } mul_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WARM,
        JMP_DIV_WAIT,
        JMP_EMIT
    } jmp_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS,
        REG_OFFSET,
        REG_SENS_TC,
        REG_OFFSET_TC,
        REG_REF_TEMP,
        REG_TEMP_SLOPE
    } cfg_reg_t;

    typedef struct packed {
        alu_op_t alu;
        mul_op_t mul;
        jmp_t    jmp;
        step_t   target;
    } ucode_t;

    localparam step_t STEP_START = 4'd0;
    localparam step_t STEP_PRESS = 4'd7;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t uc;
        uc = '{alu: OP_NONE, mul: MUL_NONE, jmp: JMP_NEXT, target: STEP_START};
        unique case (step)
            4'd0:  uc.alu = OP_DT;
            4'd1:  uc.mul = MUL_DT_SLOPE;
            4'd2:  begin uc.alu = OP_TEMP;    uc.mul = MUL_DT_OFF_TC;  end
            4'd3:  begin uc.alu = OP_OFF;     uc.mul = MUL_DT_SENS_TC; end
            4'd4:
            begin
                uc.alu    = OP_SENS;
                uc.mul    = MUL_TD_SQ;
                uc.jmp    = JMP_WARM;
                uc.target = STEP_PRESS;
            end
            4'd5:  begin uc.alu = OP_LOWCORR; uc.mul = MUL_DT_SQ;      end
            4'd6:  uc.alu = OP_TEMP2;
            4'd7:  uc.mul = MUL_RAW_SLO;
            4'd8:  begin uc.alu = OP_ACC_LO;  uc.mul = MUL_RAW_SHI;    end
            4'd9:  uc.alu = OP_ACC_HI;
            4'd10: uc.alu = OP_PDIFF;
            4'd11: uc.alu = OP_PRES;
            4'd12: uc.alu = OP_SUMS;
            4'd13: uc.alu = OP_DIV;
            4'd14: uc.jmp = JMP_DIV_WAIT;
            4'd15: begin uc.alu = OP_EMIT;    uc.jmp = JMP_EMIT;       end
            default: uc.jmp = JMP_NEXT;
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

/* rtl/bsca_qdiv.sv */
// ============================================================================
// bsca_qdiv
// Window mean in Q4: trunc(sum * 16 / WINDOW), long division by the constant
// window size, eight quotient bits per cycle.
// ============================================================================
`default_nettype none

module bsca_qdiv #(
    parameter int  WINDOW = bsca_pkg::DEF_WINDOW,
    localparam int SUM_W  = bsca_pkg::VAL_W + $clog2(WINDOW)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [SUM_W-1:0]           sum,
    output logic                              busy,
    output logic signed [bsca_pkg::AVG_W-1:0] quot
);
    import bsca_pkg::*;

    localparam int DIV_W     = SUM_W + Q_FRAC;
    localparam int DIV_STEPS = (DIV_W + DIGITS - 1) / DIGITS;
    localparam int DIV_P     = DIV_STEPS * DIGITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int REM_W     = $clog2(WINDOW) + 1;
    localparam int TRY_W     = REM_W + 1;
    localparam logic [TRY_W-1:0] WIN_C = TRY_W'(WINDOW);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DIV_P-1:0] dvd_reg;
    logic [DIV_P-1:0] quo_reg;
    logic [REM_W-1:0] rem_reg;

    logic [SUM_W-1:0]  mag_c;
    logic [REM_W-1:0]  rem_c;
    logic [DIGITS-1:0] qbits_c;
    logic [AVG_W-1:0]  q_mag;

    assign mag_c = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

    always_comb
    begin
        logic [TRY_W-1:0] trial;
        rem_c   = rem_reg;
        qbits_c = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            trial = {rem_c, dvd_reg[DIV_P-1-i]};
            if (trial >= WIN_C)
            begin
                rem_c                = REM_W'(trial - WIN_C);
                qbits_c[DIGITS-1-i] = 1'b1;
            end
            else
            begin
                rem_c = REM_W'(trial);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= sum[SUM_W-1];
            dvd_reg <= DIV_P'({mag_c, {Q_FRAC{1'b0}}});
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << DIGITS;
            quo_reg <= {quo_reg[DIV_P-DIGITS-1:0], qbits_c};
            rem_reg <= rem_c;
        end
    end

    assign q_mag = quo_reg[AVG_W-1:0];
    assign quot  = neg_reg ? (~q_mag + AVG_W'(1)) : q_mag;
    assign busy  = busy_reg;

endmodule

`default_nettype wire

/* rtl/baro_sensor_compensation_avg_top.sv */
// ============================================================================
// baro_sensor_compensation_avg_top
// Second-order compensated barometric pressure and temperature with
// moving-window means, run by a microcoded sequencer over one shared
// 26x26 multiplier.
// Temperature word: stored, no result.
// Pressure word: runs the sequencer program, with the low-temperature
// correction steps only below the reference temperature; the
// next word is taken once the result is in the output register.
// Reset: asynchronous; clears calibration, stored temperature, ring position
// and sums; ring entries read as zero until written once; input and
// calibration port are held off while reset is asserted.
// ============================================================================
`default_nettype none

module baro_sensor_compensation_avg_top #(
    parameter int WINDOW = bsca_pkg::DEF_WINDOW
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic [bsca_pkg::RAW_W-1:0]            raw_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [bsca_pkg::VAL_W-1:0]     pressure_now,
    output logic signed [bsca_pkg::VAL_W-1:0]     temperature_now,
    output logic signed [bsca_pkg::AVG_W-1:0]     pressure_avg_q4,
    output logic signed [bsca_pkg::AVG_W-1:0]     temperature_avg_q4,
    output logic                                  low_temp_corrected,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bsca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bsca_pkg::CAL_W-1:0]            cfg_data
);
    import bsca_pkg::*;

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = VAL_W + $clog2(WINDOW);

    // calibration
    logic [CAL_W-1:0] cal_sens_reg;
    logic [CAL_W-1:0] cal_offset_reg;
    logic [CAL_W-1:0] cal_sens_tc_reg;
    logic [CAL_W-1:0] cal_offset_tc_reg;
    logic [CAL_W-1:0] cal_ref_temp_reg;
    logic [CAL_W-1:0] cal_temp_slope_reg;

    // sequencer
    seq_state_t state_reg, state_next;
    step_t      step_reg, step_next;
    ucode_t     uc;
    logic       ready_reg;

    // datapath
    logic [RAW_W-1:0]         temp_raw_reg;
    logic [RAW_W-1:0]         raw_reg;
    logic signed [DT_W-1:0]   dt_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [OS_W-1:0]   off_reg;
    logic signed [OS_W-1:0]   sens_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [VAL_W-1:0]  p_reg;
    logic                     low_reg;

    // rings
    logic signed [VAL_W-1:0] mem_p [WINDOW];
    logic signed [VAL_W-1:0] mem_t [WINDOW];
    logic signed [VAL_W-1:0] rd_p_reg;
    logic signed [VAL_W-1:0] rd_t_reg;
    logic [PTR_W-1:0]        pos_reg;
    logic                    wrapped_reg;
    logic signed [SUM_W-1:0] psum_reg;
    logic signed [SUM_W-1:0] tsum_reg;

    // output word
    logic                     out_valid_reg;
    logic signed [VAL_W-1:0]  pressure_now_reg;
    logic signed [VAL_W-1:0]  temperature_now_reg;
    logic signed [AVG_W-1:0]  pressure_avg_reg;
    logic signed [AVG_W-1:0]  temperature_avg_reg;
    logic                     low_out_reg;

    logic                     in_accept_c;
    logic                     out_busy_c;
    logic                     hold_c;
    logic                     exec_c;
    logic                     low_c;
    logic                     emit_c;
    logic                     div_start_c;
    logic                     div_busy_p;
    logic                     div_busy_t;
    logic signed [AVG_W-1:0]  quot_p;
    logic signed [AVG_W-1:0]  quot_t;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [TEMP_W-1:0] td_c;
    logic signed [PROD_W-1:0] prod_rnd_c;
    logic signed [ACC_W-1:0]  acc_rnd_c;
    logic signed [OS_W-1:0]   off_tc_c;
    logic signed [OS_W-1:0]   sens_tc_c;
    logic signed [OS_W-1:0]   a_c;
    logic signed [OS_W-1:0]   five_a_c;
    logic signed [VAL_W-1:0]  t32_c;
    logic signed [VAL_W-1:0]  old_p_c;
    logic signed [VAL_W-1:0]  old_t_c;

    assign uc          = ucode_rom(step_reg);
    assign in_stall    = (state_reg != SEQ_IDLE) || !ready_reg;
    assign in_accept_c = in_valid && !in_stall;
    assign out_busy_c  = out_valid_reg && out_stall;
    assign low_c       = (temp_reg < TEMP_REF);
    assign hold_c      = ((uc.jmp == JMP_DIV_WAIT) && (div_busy_p || div_busy_t)) ||
                         ((uc.jmp == JMP_EMIT) && out_busy_c);
    assign exec_c      = (state_reg == SEQ_RUN) && !hold_c;
    assign emit_c      = exec_c && (uc.alu == OP_EMIT);
    assign div_start_c = exec_c && (uc.alu == OP_DIV);

    // ---------------- configuration ----------------
    assign cfg_ready = ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_sens_reg       <= '0;
            cal_offset_reg     <= '0;
            cal_sens_tc_reg    <= '0;
            cal_offset_tc_reg  <= '0;
            cal_ref_temp_reg   <= '0;
            cal_temp_slope_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SENS:       cal_sens_reg       <= cfg_data;
                REG_OFFSET:     cal_offset_reg     <= cfg_data;
                REG_SENS_TC:    cal_sens_tc_reg    <= cfg_data;
                REG_OFFSET_TC:  cal_offset_tc_reg  <= cfg_data;
                REG_REF_TEMP:   cal_ref_temp_reg   <= cfg_data;
                REG_TEMP_SLOPE: cal_temp_slope_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            step_reg  <= STEP_START;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_accept_c && action)
                begin
                    state_next = SEQ_RUN;
                    step_next  = STEP_START;
                end
            end
            SEQ_RUN:
            begin
                if (!hold_c)
                begin
                    case (uc.jmp)
                        JMP_WARM:
                        begin
                            step_next = low_c ? (step_reg + STEP_W'(1)) : uc.target;
                        end
                        JMP_EMIT:
                        begin
                            state_next = SEQ_IDLE;
                            step_next  = STEP_START;
                        end
                        default: step_next = step_reg + STEP_W'(1);
                    endcase
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // ---------------- shared multiplier ----------------
    assign td_c = temp_reg - TEMP_REF;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uc.mul)
            MUL_DT_SLOPE:
            begin
                mul_a = MUL_W'(dt_reg);
                mul_b = MUL_W'({1'b0, cal_temp_slope_reg});
            end
            MUL_DT_OFF_TC:
            begin
                mul_a = MUL_W'(dt_reg);
                mul_b = MUL_W'({1'b0, cal_offset_tc_reg});
            end
            MUL_DT_SENS_TC:
            begin
                mul_a = MUL_W'(dt_reg);
                mul_b = MUL_W'({1'b0, cal_sens_tc_reg});
            end
            MUL_TD_SQ:
            begin
                mul_a = MUL_W'(td_c);
                mul_b = MUL_W'(td_c);
            end
            MUL_DT_SQ:
            begin
                mul_a = MUL_W'(dt_reg);
                mul_b = MUL_W'(dt_reg);
            end
            MUL_RAW_SLO:
            begin
                mul_a = MUL_W'({1'b0, raw_reg});
                mul_b = MUL_W'({1'b0, sens_reg[SENS_SPLIT-1:0]});
            end
            MUL_RAW_SHI:
            begin
                mul_a = MUL_W'({1'b0, raw_reg});
                mul_b = MUL_W'($signed(sens_reg[OS_W-1:SENS_SPLIT]));
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------- ALU ----------------
    // round toward zero before the arithmetic shifts
    assign prod_rnd_c = prod_reg + (prod_reg[PROD_W-1] ?
                        PROD_W'((64'd1 << TEMP_SHIFT) - 64'd1) : PROD_W'(0));
    assign acc_rnd_c  = acc_reg + (acc_reg[ACC_W-1] ?
                        ACC_W'((64'd1 << P_DIV_SHIFT) - 64'd1) : ACC_W'(0));
    assign off_tc_c   = OS_W'(prod_reg >>> OFF_TC_SHIFT);
    assign sens_tc_c  = OS_W'(prod_reg >>> SENS_TC_SHIFT);
    assign a_c        = OS_W'(prod_reg);
    assign five_a_c   = (a_c <<< 2) + a_c;
    assign t32_c      = VAL_W'(temp_reg);

    always_ff @(posedge clk)
    begin
        if (in_accept_c && action)
        begin
            raw_reg <= raw_value;
        end
        if (exec_c)
        begin
            if (uc.mul != MUL_NONE)
            begin
                prod_reg <= mul_p;
            end
            case (uc.alu)
                OP_DT:
                begin
                    dt_reg <= DT_W'({2'b00, temp_raw_reg}) -
                              DT_W'({2'b00, cal_ref_temp_reg, {REF_TEMP_SHIFT{1'b0}}});
                end
                OP_TEMP:    temp_reg <= TEMP_REF + TEMP_W'(prod_rnd_c >>> TEMP_SHIFT);
                OP_OFF:
                begin
                    off_reg <= OS_W'({cal_offset_reg, {OFFSET_SHIFT{1'b0}}}) + off_tc_c;
                end
                OP_SENS:
                begin
                    sens_reg <= OS_W'({cal_sens_reg, {SENS_SHIFT{1'b0}}}) + sens_tc_c;
                    low_reg  <= low_c;
                end
                OP_LOWCORR:
                begin
                    off_reg  <= off_reg - (five_a_c >>> 1);
                    sens_reg <= sens_reg - (five_a_c >>> 2);
                end
                OP_TEMP2:   temp_reg <= temp_reg - TEMP_W'(prod_reg >>> DT2_SHIFT);
                OP_ACC_LO:  acc_reg <= ACC_W'(prod_reg);
                OP_ACC_HI:  acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< SENS_SPLIT);
                OP_PDIFF:   acc_reg <= (acc_reg >>> P_SHIFT) - ACC_W'(off_reg);
                OP_PRES:    p_reg <= VAL_W'(acc_rnd_c >>> P_DIV_SHIFT);
                default: ;
            endcase
        end
    end

    // ---------------- rings and running sums ----------------
    assign old_p_c = wrapped_reg ? rd_p_reg : '0;
    assign old_t_c = wrapped_reg ? rd_t_reg : '0;

    always_ff @(posedge clk)
    begin
        if (exec_c && (uc.alu == OP_SUMS))
        begin
            mem_p[pos_reg] <= p_reg;
            mem_t[pos_reg] <= t32_c;
        end
        if (in_accept_c && action)
        begin
            rd_p_reg <= mem_p[pos_reg];
            rd_t_reg <= mem_t[pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_raw_reg <= '0;
            pos_reg      <= '0;
            wrapped_reg  <= 1'b0;
            psum_reg     <= '0;
            tsum_reg     <= '0;
        end
        else
        begin
            if (in_accept_c && !action)
            begin
                temp_raw_reg <= raw_value;
            end
            if (exec_c && (uc.alu == OP_SUMS))
            begin
                psum_reg <= psum_reg + SUM_W'(p_reg) - SUM_W'(old_p_c);
                tsum_reg <= tsum_reg + SUM_W'(t32_c) - SUM_W'(old_t_c);
                if (pos_reg == PTR_W'(WINDOW - 1))
                begin
                    pos_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + PTR_W'(1);
                end
            end
        end
    end

    bsca_qdiv #(
        .WINDOW (WINDOW)
    ) u_div_p (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_c),
        .sum   (psum_reg),
        .busy  (div_busy_p),
        .quot  (quot_p)
    );

    bsca_qdiv #(
        .WINDOW (WINDOW)
    ) u_div_t (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_c),
        .sum   (tsum_reg),
        .busy  (div_busy_t),
        .quot  (quot_t)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_c)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_c)
        begin
            pressure_now_reg    <= p_reg;
            temperature_now_reg <= t32_c;
            pressure_avg_reg    <= quot_p;
            temperature_avg_reg <= quot_t;
            low_out_reg         <= low_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign pressure_now       = pressure_now_reg;
    assign temperature_now    = temperature_now_reg;
    assign pressure_avg_q4    = pressure_avg_reg;
    assign temperature_avg_q4 = temperature_avg_reg;
    assign low_temp_corrected = low_out_reg;

endmodule

`default_nettype wire

/* rtl/bsca_check.sv */
// ============================================================================
// bsca_check
// Port-level checks on the compensation block, bound to the top level.
// ============================================================================
`default_nettype none

module bsca_check (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  action,
    input  logic [bsca_pkg::RAW_W-1:0]            raw_value,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [bsca_pkg::VAL_W-1:0]     pressure_now,
    input  logic signed [bsca_pkg::VAL_W-1:0]     temperature_now,
    input  logic signed [bsca_pkg::AVG_W-1:0]     pressure_avg_q4,
    input  logic signed [bsca_pkg::AVG_W-1:0]     temperature_avg_q4,
    input  logic                                  low_temp_corrected,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [bsca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bsca_pkg::CAL_W-1:0]            cfg_data
);
    import bsca_pkg::*;

    logic signed [VAL_W-1:0] temp_ref_c;

    assign temp_ref_c = VAL_W'(TEMP_REF);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pressure_now) &&
        $stable(temperature_now) && $stable(pressure_avg_q4) &&
        $stable(temperature_avg_q4) && $stable(low_temp_corrected))
        else $error("result word changed while stalled");

    // pressure word occupies the sequencer
    a_press_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action |=> in_stall)
        else $error("input not stalled after pressure word");

    // temperature word only updates storage
    a_temp_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !action |=> !in_stall)
        else $error("input stalled after temperature word");

    // correction flag agrees with the reported temperature
    a_low_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (low_temp_corrected == (temperature_now < temp_ref_c)))
        else $error("low temperature flag inconsistent with temperature");

    logic unused_c;
    assign unused_c = ^{raw_value, cfg_valid, cfg_ready, cfg_index, cfg_data};

endmodule

bind baro_sensor_compensation_avg_top bsca_check u_bsca_check (.*);

`default_nettype wire
